// File: sv/swept_sphere_collision_test_top_macros.svh
// ============================================================================
// swept_sphere_collision_test_top_macros
// Assertion helpers for the swept sphere collision test.
// ============================================================================
`ifndef SWEPT_SPHERE_COLLISION_TEST_TOP_MACROS_SVH
`define SWEPT_SPHERE_COLLISION_TEST_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SSCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ssct_pkg.sv
// ============================================================================
// ssct_pkg
// Widths of the fixed-point quantities in the swept sphere collision test.
// ============================================================================
`default_nettype none

package ssct_pkg;
  localparam int CoordW = 32;  // Q16.16 coordinates and displacement
  localparam int RadW   = 24;  // Q8.16 radius
  localparam int DiffW  = 33;  // centre difference
  localparam int RsumW  = 25;  // radius sum
  localparam int C2W    = 66;  // |c|^2
  localparam int M2W    = 64;  // |M|^2
  localparam int ProdW  = 65;  // one term of M.c
  localparam int DotW   = 67;  // M.c, signed
  localparam int NumW   = 65;  // non-negative M.c as dividend
  localparam int LenCW  = 33;  // |c| and square root of |M|^2 padded
  localparam int LenMW  = 32;  // |M|
  localparam int DW     = 34;  // projection d
  localparam int RsqW   = 50;  // r^2
  localparam int DsqW   = 68;  // d^2
  localparam int LhsW   = 69;  // r^2 + d^2
  localparam int SW     = 35;  // sqrt(r^2 - f)
endpackage

`default_nettype wire

// File: sv/swept_sphere_collision_test_top.sv
// ============================================================================
// swept_sphere_collision_test_top
// Swept sphere against sphere hit test on signed Q16.16 inputs.
// ============================================================================
// Usage: one sphere pair enters on the input channel (in_valid/in_ready) as
// a word of two centres, two radii and the displacement; one word carrying
// the hit flag leaves on the output channel (out_valid/out_ready) for each
// pair, in order.
// Throughput is one pair per cycle while in_ready is high. The path from acceptance to
// out_valid runs through the chain of one-bit-per-stage units: a 33 stage square
// root for |M| and |c|, a 34 stage divider for the projection and a 35 stage
// square root for the chord half length, plus six arithmetic stages and the
// output queue register.
// The result lands in a two entry output queue. While the receiver stalls,
// the pipeline keeps moving until that queue is full; then in_ready drops
// and the whole pipeline holds, so nothing is lost or repeated.
// Reset empties the pipeline and the queue; the data registers are not reset.
// ============================================================================
`default_nettype none

`include "swept_sphere_collision_test_top_macros.svh"

module swept_sphere_collision_test_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ssct_pkg::CoordW-1:0]  centre_a_x,
  input  logic signed [ssct_pkg::CoordW-1:0]  centre_a_y,
  input  logic signed [ssct_pkg::CoordW-1:0]  centre_a_z,
  input  logic signed [ssct_pkg::CoordW-1:0]  centre_b_x,
  input  logic signed [ssct_pkg::CoordW-1:0]  centre_b_y,
  input  logic signed [ssct_pkg::CoordW-1:0]  centre_b_z,
  input  logic        [ssct_pkg::RadW-1:0]    radius_a,
  input  logic        [ssct_pkg::RadW-1:0]    radius_b,
  input  logic signed [ssct_pkg::CoordW-1:0]  move_x,
  input  logic signed [ssct_pkg::CoordW-1:0]  move_y,
  input  logic signed [ssct_pkg::CoordW-1:0]  move_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                hit
);
  import ssct_pkg::*;

  localparam int Side1W = C2W + DotW;
  localparam int DivSideW = C2W + RsumW + LenMW + 2;
  localparam int Side2W = LenMW + DW + 1;

  logic en;

  // Stage 1: centre differences and radius sum.
  logic                     s1_v;
  logic signed [DiffW-1:0]  s1_cx, s1_cy, s1_cz;
  logic signed [CoordW-1:0] s1_mx, s1_my, s1_mz;
  logic [RsumW-1:0]         s1_rsum;

  // Stage 2: squares and component products of c and M.
  logic                     s2_v;
  logic signed [C2W-1:0]    s2_ccx, s2_ccy, s2_ccz;
  logic signed [M2W-1:0]    s2_mmx, s2_mmy, s2_mmz;
  logic signed [ProdW-1:0]  s2_cmx, s2_cmy, s2_cmz;
  logic [RsumW-1:0]         s2_rsum;

  // Stage 3: sums.
  logic                     s3_v;
  logic [C2W-1:0]           s3_c2;
  logic [M2W-1:0]           s3_m2;
  logic signed [DotW-1:0]   s3_dot;
  logic [RsumW-1:0]         s3_rsum;

  // Square roots of |M|^2 and |c|^2.
  logic                     q1_v;
  logic                     q1c_v;
  logic [LenCW-1:0]         q1_lenm, q1_lenc;
  logic [RsumW-1:0]         q1_rsum;
  logic [Side1W-1:0]        q1_side;
  logic [C2W-1:0]           q1_c2;
  logic signed [DotW-1:0]   q1_dot;
  logic [LenCW:0]           q1_reach;

  // Stage 4: early escape and dividend setup.
  logic                     s4_v;
  logic [NumW-1:0]          s4_num;
  logic [LenMW-1:0]         s4_lenm;
  logic [C2W-1:0]           s4_c2;
  logic [RsumW-1:0]         s4_rsum;
  logic                     s4_rej;
  logic                     s4_zero;

  // Divider output.
  logic                     dv_v;
  logic [DW-1:0]            dv_quot;
  logic [DivSideW-1:0]      dv_side;
  logic [C2W-1:0]           dv_c2;
  logic [RsumW-1:0]         dv_rsum;
  logic [LenMW-1:0]         dv_lenm;
  logic                     dv_rej;
  logic                     dv_zero;
  logic [DW-1:0]            dv_d;

  // Stage 5: squares of d and r.
  logic                     s5_v;
  logic [DsqW-1:0]          s5_dsq;
  logic [RsqW-1:0]          s5_rsq;
  logic [C2W-1:0]           s5_c2;
  logic [LenMW-1:0]         s5_lenm;
  logic [DW-1:0]            s5_d;
  logic                     s5_rej;

  // Stage 6: wide pass test and chord radicand.
  logic                     s6_v;
  logic [2*SW-1:0]          s6_rad;
  logic [LenMW-1:0]         s6_lenm;
  logic [DW-1:0]            s6_d;
  logic                     s6_rej;
  logic [LhsW-1:0]          s5_lhs;

  // Chord square root output and final test.
  logic                     q2_v;
  logic [SW-1:0]            q2_root;
  logic [Side2W-1:0]        q2_side;
  logic [LenMW-1:0]         q2_lenm;
  logic [DW-1:0]            q2_d;
  logic                     q2_rej;
  logic                     fin_hit;

  // Output queue.
  logic [1:0]               cnt;
  logic                     q0, q1;
  logic                     push, pop;

  assign en       = (cnt != 2'd2);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= q1_v;
      s5_v <= dv_v;
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cx   <= DiffW'(centre_b_x) - DiffW'(centre_a_x);
      s1_cy   <= DiffW'(centre_b_y) - DiffW'(centre_a_y);
      s1_cz   <= DiffW'(centre_b_z) - DiffW'(centre_a_z);
      s1_mx   <= move_x;
      s1_my   <= move_y;
      s1_mz   <= move_z;
      s1_rsum <= RsumW'(radius_a) + RsumW'(radius_b);

      s2_ccx  <= C2W'(s1_cx) * C2W'(s1_cx);
      s2_ccy  <= C2W'(s1_cy) * C2W'(s1_cy);
      s2_ccz  <= C2W'(s1_cz) * C2W'(s1_cz);
      s2_mmx  <= M2W'(s1_mx) * M2W'(s1_mx);
      s2_mmy  <= M2W'(s1_my) * M2W'(s1_my);
      s2_mmz  <= M2W'(s1_mz) * M2W'(s1_mz);
      s2_cmx  <= ProdW'(s1_cx) * ProdW'(s1_mx);
      s2_cmy  <= ProdW'(s1_cy) * ProdW'(s1_my);
      s2_cmz  <= ProdW'(s1_cz) * ProdW'(s1_mz);
      s2_rsum <= s1_rsum;

      s3_c2   <= C2W'(unsigned'(s2_ccx)) + C2W'(unsigned'(s2_ccy))
               + C2W'(unsigned'(s2_ccz));
      s3_m2   <= M2W'(unsigned'(s2_mmx)) + M2W'(unsigned'(s2_mmy))
               + M2W'(unsigned'(s2_mmz));
      s3_dot  <= DotW'(s2_cmx) + DotW'(s2_cmy) + DotW'(s2_cmz);
      s3_rsum <= s2_rsum;
    end
  end

  ssct_sqrt_pipe #(.RootW(LenCW), .SideW(RsumW)) u_sqrt_m (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_v),
    .in_rad    ({2'b00, s3_m2}),
    .in_side   (s3_rsum),
    .out_valid (q1_v),
    .out_root  (q1_lenm),
    .out_side  (q1_rsum)
  );

  ssct_sqrt_pipe #(.RootW(LenCW), .SideW(Side1W)) u_sqrt_c (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_v),
    .in_rad    (s3_c2),
    .in_side   ({s3_c2, s3_dot}),
    .out_valid (q1c_v),
    .out_root  (q1_lenc),
    .out_side  (q1_side)
  );

  assign q1_c2    = q1_side[Side1W-1 -: C2W];
  assign q1_dot   = signed'(q1_side[DotW-1:0]);
  assign q1_reach = (LenCW+1)'(q1_lenm) + (LenCW+1)'(q1_rsum);

  // A receding pair feeds a zero dividend so the divider stays in range.
  always_ff @(posedge clk) begin
    if (en) begin
      s4_num  <= (q1_dot < 0) ? '0 : q1_dot[NumW-1:0];
      s4_lenm <= q1_lenm[LenMW-1:0];
      s4_c2   <= q1_c2;
      s4_rsum <= q1_rsum;
      s4_rej  <= (q1_reach < (LenCW+1)'(q1_lenc)) || (q1_dot < 0);
      s4_zero <= (q1_lenm == '0);
    end
  end

  ssct_div_pipe #(.NumW(NumW), .QW(DW), .DivW(LenMW), .SideW(DivSideW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s4_v),
    .in_num    (s4_num),
    .in_div    (s4_lenm),
    .in_side   ({s4_c2, s4_rsum, s4_lenm, s4_rej, s4_zero}),
    .out_valid (dv_v),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  assign dv_c2   = dv_side[DivSideW-1 -: C2W];
  assign dv_rsum = dv_side[LenMW+2 +: RsumW];
  assign dv_lenm = dv_side[2 +: LenMW];
  assign dv_rej  = dv_side[1];
  assign dv_zero = dv_side[0];
  assign dv_d    = dv_zero ? '0 : dv_quot;

  assign s5_lhs = LhsW'(s5_rsq) + LhsW'(s5_dsq);

  always_ff @(posedge clk) begin
    if (en) begin
      s5_dsq  <= DsqW'(dv_d) * DsqW'(dv_d);
      s5_rsq  <= RsqW'(dv_rsum) * RsqW'(dv_rsum);
      s5_c2   <= dv_c2;
      s5_lenm <= dv_lenm;
      s5_d    <= dv_d;
      s5_rej  <= dv_rej;

      s6_rad  <= (2*SW)'(s5_lhs - LhsW'(s5_c2));
      s6_lenm <= s5_lenm;
      s6_d    <= s5_d;
      s6_rej  <= s5_rej || (LhsW'(s5_c2) >= s5_lhs);
    end
  end

  ssct_sqrt_pipe #(.RootW(SW), .SideW(Side2W)) u_sqrt_s (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s6_v),
    .in_rad    (s6_rad),
    .in_side   ({s6_lenm, s6_d, s6_rej}),
    .out_valid (q2_v),
    .out_root  (q2_root),
    .out_side  (q2_side)
  );

  assign q2_lenm = q2_side[Side2W-1 -: LenMW];
  assign q2_d    = q2_side[1 +: DW];
  assign q2_rej  = q2_side[0];
  assign fin_hit = !q2_rej && (((SW+1)'(q2_lenm) + (SW+1)'(q2_root)) >= (SW+1)'(q2_d));

  assign push      = en && q2_v;
  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt != 2'd0);
  assign hit       = q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  // Two word queue: q0 is the head shown on the output.
  always_ff @(posedge clk) begin
    if (pop) begin
      q0 <= (cnt == 2'd2) ? q1 : fin_hit;
      if (push) begin
        q1 <= fin_hit;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        q0 <= fin_hit;
      end else begin
        q1 <= fin_hit;
      end
    end
  end

  `SSCT_ASSERT_NOW(a_cnt_range, 1'b1, cnt != 2'd3, "output queue count out of range")
  `SSCT_ASSERT_NOW(a_full_stalls, cnt == 2'd2, !in_ready && !push, "full queue still accepts")
  `SSCT_ASSERT_NEXT(a_drain, pop && (cnt == 2'd2), cnt == 2'd1, "queue drain miscounted")
  `SSCT_ASSERT_NOW(a_roots_aligned, 1'b1, q1c_v == q1_v, "square root pipes out of step")
endmodule

`default_nettype wire

// File: sv/ssct_sqrt_pipe.sv
// ============================================================================
// ssct_sqrt_pipe
// Pipelined floor square root, one result bit per stage, with a sideband
// word that travels alongside.
// ============================================================================
`default_nettype none

module ssct_sqrt_pipe #(
  parameter int RootW = 33,
  parameter int SideW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2*RootW-1:0]   in_rad,
  input  logic [SideW-1:0]     in_side,
  output logic                 out_valid,
  output logic [RootW-1:0]     out_root,
  output logic [SideW-1:0]     out_side
);
  localparam int RadW = 2 * RootW;
  localparam int RemW = RootW + 3;

  logic [RootW-1:0] vld;
  logic [RemW-1:0]  rem  [RootW];
  logic [RootW-1:0] root [RootW];
  logic [RadW-1:0]  rad  [RootW];
  logic [SideW-1:0] side [RootW];

  for (genvar s = 0; s < RootW; s++) begin : g_stage
    logic             pv;
    logic [RemW-1:0]  prem;
    logic [RootW-1:0] proot;
    logic [RadW-1:0]  prad;
    logic [SideW-1:0] pside;
    logic [RemW-1:0]  rem_sh;
    logic [RemW-1:0]  trial;
    logic             ge;

    if (s == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = '0;
      assign proot = '0;
      assign prad  = in_rad;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = vld[s-1];
      assign prem  = rem[s-1];
      assign proot = root[s-1];
      assign prad  = rad[s-1];
      assign pside = side[s-1];
    end

    // Bring down the next two radicand bits and try the candidate 4*root+1.
    always_comb begin
      rem_sh = {prem[RemW-3:0], prad[RadW-1 -: 2]};
      trial  = {1'b0, proot, 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]  <= ge ? (rem_sh - trial) : rem_sh;
        root[s] <= {proot[RootW-2:0], ge};
        rad[s]  <= prad << 2;
        side[s] <= pside;
      end
    end
  end

  assign out_valid = vld[RootW-1];
  assign out_root  = root[RootW-1];
  assign out_side  = side[RootW-1];
endmodule

`default_nettype wire

// File: sv/ssct_div_pipe.sv
// ============================================================================
// ssct_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ============================================================================
`default_nettype none

module ssct_div_pipe #(
  parameter int NumW  = 65,
  parameter int QW    = 34,
  parameter int DivW  = 32,
  parameter int SideW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NumW-1:0]   in_num,
  input  logic [DivW-1:0]   in_div,
  input  logic [SideW-1:0]  in_side,
  output logic              out_valid,
  output logic [QW-1:0]     out_quot,
  output logic [SideW-1:0]  out_side
);
  localparam int HiW = NumW - QW;

  logic [QW-1:0]    vld;
  logic [DivW-1:0]  rem  [QW];
  logic [QW-1:0]    num  [QW];
  logic [DivW-1:0]  dvs  [QW];
  logic [SideW-1:0] side [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic             pv;
    logic [DivW-1:0]  prem;
    logic [QW-1:0]    pnum;
    logic [DivW-1:0]  pdvs;
    logic [SideW-1:0] pside;
    logic [DivW:0]    rem_sh;
    logic [DivW:0]    diff;
    logic             ge;

    if (s == 0) begin : g_first
      // The upper dividend bits are below the divisor whenever the quotient fits.
      assign pv    = in_valid;
      assign prem  = {{(DivW-HiW){1'b0}}, in_num[NumW-1:QW]};
      assign pnum  = in_num[QW-1:0];
      assign pdvs  = in_div;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = vld[s-1];
      assign prem  = rem[s-1];
      assign pnum  = num[s-1];
      assign pdvs  = dvs[s-1];
      assign pside = side[s-1];
    end

    always_comb begin
      rem_sh = {prem, pnum[QW-1]};
      diff   = rem_sh - {1'b0, pdvs};
      ge     = (rem_sh >= {1'b0, pdvs});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= pv;
      end
    end

    // Dividend bits leave at the top while quotient bits enter at the bottom.
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]  <= ge ? diff[DivW-1:0] : rem_sh[DivW-1:0];
        num[s]  <= {pnum[QW-2:0], ge};
        dvs[s]  <= pdvs;
        side[s] <= pside;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign out_quot  = num[QW-1];
  assign out_side  = side[QW-1];
endmodule

`default_nettype wire
